// ----- src/pmsrfp_pkg.sv -----
// Package for the particulate sensor reply frame parser.
// Frame byte codes, command and action codes, result kinds and reset values.
// No dependencies.
package pmsrfp_pkg;

    localparam logic [7:0] HEAD_BYTE    = 8'hAA;
    localparam logic [7:0] TAIL_BYTE    = 8'hAB;
    localparam logic [7:0] CMD_DATA     = 8'hC0;
    localparam logic [7:0] CMD_REPLY    = 8'hC5;
    localparam logic [7:0] ACT_MODE     = 8'd2;
    localparam logic [7:0] ACT_STATE    = 8'd6;
    localparam logic [7:0] ACT_VERSION  = 8'd7;
    localparam logic [7:0] ACT_INTERVAL = 8'd8;

    localparam int FRAME_STORE_DEPTH = 8;

    localparam logic [3:0] POS_HUNT      = 4'd0;
    localparam logic [3:0] POS_FIRST     = 4'd1;
    localparam logic [3:0] POS_SUM_FIRST = 4'd2;
    localparam logic [3:0] POS_SUM_LAST  = 4'd7;
    localparam logic [3:0] POS_STORE_END = 4'd8;
    localparam logic [3:0] POS_TAIL      = 4'd9;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    localparam logic [7:0] FW_YEAR_RST  = 8'd15;
    localparam logic [7:0] FW_MONTH_RST = 8'd7;
    localparam logic [7:0] FW_DAY_RST   = 8'd10;

endpackage

// ----- src/pmsrfp_stream_if.sv -----
// Valid/ready channels of the frame parser: received byte in, frame result out.
// No dependencies.
interface pmsrfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmsrfp_result_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [1:0]  frame_kind;
    logic [15:0] pm25_tenths;
    logic [15:0] pm10_tenths;
    logic        passive_mode;
    logic        awake;
    logic [7:0]  interval_min;
    logic [7:0]  fw_year;
    logic [7:0]  fw_month;
    logic [7:0]  fw_day;
    logic [15:0] sensor_id;

    modport source (output valid, output frame_ok, output frame_kind, output pm25_tenths,
                    output pm10_tenths, output passive_mode, output awake,
                    output interval_min, output fw_year, output fw_month, output fw_day,
                    output sensor_id, input ready);
    modport sink   (input valid, input frame_ok, input frame_kind, input pm25_tenths,
                    input pm10_tenths, input passive_mode, input awake,
                    input interval_min, input fw_year, input fw_month, input fw_day,
                    input sensor_id, output ready);
endinterface

// ----- src/pm_sensor_reply_frame_parser.sv -----
// Particulate sensor reply frame parser, top level.
// Depends on pmsrfp_pkg and the channel interfaces in pmsrfp_stream_if.sv.
//
// Takes one received serial word per cycle while not stalled, and hunts for the head byte
// 0xAA; the ten-byte frame that follows is checked for tail 0xAB and for the checksum over
// payload bytes 2 to 7. A word passes an input register and then the frame logic; on the
// tail word one result word is loaded into the output register. Input stalls only while a
// finished result waits in the output register and the word in the input register is
// itself a tail. Valid data frames update PM2.5 and PM10; valid reply frames update mode,
// work state, interval or firmware date.
module pm_sensor_reply_frame_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    pmsrfp_byte_if.sink            rx,
    pmsrfp_result_if.source        result
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic [3:0]  pos_reg,       pos_next;
    logic [7:0]  store_reg [pmsrfp_pkg::FRAME_STORE_DEPTH];
    logic [7:0]  sum_reg,       sum_next;
    logic [15:0] pm25_reg,      pm25_next;
    logic [15:0] pm10_reg,      pm10_next;
    logic        passive_reg,   passive_next;
    logic        awake_reg,     awake_next;
    logic [7:0]  interval_reg,  interval_next;
    logic [7:0]  fw_year_reg,   fw_year_next;
    logic [7:0]  fw_month_reg,  fw_month_next;
    logic [7:0]  fw_day_reg,    fw_day_next;

    logic        out_valid_reg, out_valid_next;
    logic        ok_reg;
    logic [1:0]  kind_reg;
    logic [15:0] id_reg;

    logic        is_tail;
    logic        stage_advance;
    logic        step;
    logic        frame_ok;
    logic [1:0]  frame_kind;
    logic [2:0]  store_idx;
    logic [3:0]  pos_inc;

    assign is_tail       = (pos_reg == pmsrfp_pkg::POS_TAIL);
    assign stage_advance = !in_valid_reg || !is_tail || !out_valid_reg || result.ready;
    assign step          = in_valid_reg && stage_advance;
    assign rx.ready      = stage_advance;
    assign pos_inc       = pos_reg + 4'd1;
    assign store_idx     = pos_reg[2:0] - 3'd1;

    assign frame_ok   = (in_byte_reg == pmsrfp_pkg::TAIL_BYTE) && (sum_reg == store_reg[7]);
    assign frame_kind = (store_reg[0] == pmsrfp_pkg::CMD_DATA)  ? pmsrfp_pkg::KIND_DATA  :
                        (store_reg[0] == pmsrfp_pkg::CMD_REPLY) ? pmsrfp_pkg::KIND_REPLY :
                                                                  pmsrfp_pkg::KIND_OTHER;

    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        pm25_next     = pm25_reg;
        pm10_next     = pm10_reg;
        passive_next  = passive_reg;
        awake_next    = awake_reg;
        interval_next = interval_reg;
        fw_year_next  = fw_year_reg;
        fw_month_next = fw_month_reg;
        fw_day_next   = fw_day_reg;
        if (pos_reg == pmsrfp_pkg::POS_HUNT || pos_reg > pmsrfp_pkg::POS_TAIL)
        begin
            pos_next = pmsrfp_pkg::POS_HUNT;
            if (in_byte_reg == pmsrfp_pkg::HEAD_BYTE)
            begin
                pos_next = pmsrfp_pkg::POS_FIRST;
                sum_next = 8'd0;
            end
        end
        else if (pos_reg <= pmsrfp_pkg::POS_STORE_END)
        begin
            if (pos_reg >= pmsrfp_pkg::POS_SUM_FIRST && pos_reg <= pmsrfp_pkg::POS_SUM_LAST)
            begin
                sum_next = sum_reg + in_byte_reg;
            end
            pos_next = pos_inc;
        end
        else
        begin
            pos_next = pmsrfp_pkg::POS_HUNT;
            if (frame_ok && frame_kind == pmsrfp_pkg::KIND_DATA)
            begin
                pm25_next = {store_reg[2], store_reg[1]};
                pm10_next = {store_reg[4], store_reg[3]};
            end
            else if (frame_ok && frame_kind == pmsrfp_pkg::KIND_REPLY)
            begin
                case (store_reg[1])
                    pmsrfp_pkg::ACT_MODE:     passive_next  = (store_reg[3] != 8'd0);
                    pmsrfp_pkg::ACT_STATE:    awake_next    = (store_reg[3] != 8'd0);
                    pmsrfp_pkg::ACT_INTERVAL: interval_next = store_reg[3];
                    pmsrfp_pkg::ACT_VERSION:
                    begin
                        fw_year_next  = store_reg[2];
                        fw_month_next = store_reg[3];
                        fw_day_next   = store_reg[4];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (step && is_tail)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= pmsrfp_pkg::POS_HUNT;
            sum_reg       <= 8'd0;
            pm25_reg      <= 16'd0;
            pm10_reg      <= 16'd0;
            passive_reg   <= 1'b0;
            awake_reg     <= 1'b1;
            interval_reg  <= 8'd0;
            fw_year_reg   <= pmsrfp_pkg::FW_YEAR_RST;
            fw_month_reg  <= pmsrfp_pkg::FW_MONTH_RST;
            fw_day_reg    <= pmsrfp_pkg::FW_DAY_RST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (stage_advance)
            begin
                in_valid_reg <= rx.valid;
            end
            if (step)
            begin
                pos_reg      <= pos_next;
                sum_reg      <= sum_next;
                pm25_reg     <= pm25_next;
                pm10_reg     <= pm10_next;
                passive_reg  <= passive_next;
                awake_reg    <= awake_next;
                interval_reg <= interval_next;
                fw_year_reg  <= fw_year_next;
                fw_month_reg <= fw_month_next;
                fw_day_reg   <= fw_day_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_advance && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (step && pos_reg != pmsrfp_pkg::POS_HUNT && pos_reg <= pmsrfp_pkg::POS_STORE_END)
        begin
            store_reg[store_idx] <= in_byte_reg;
        end
        if (step && is_tail)
        begin
            ok_reg   <= frame_ok;
            kind_reg <= frame_kind;
            id_reg   <= {store_reg[5], store_reg[6]};
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.frame_ok     = ok_reg;
    assign result.frame_kind   = kind_reg;
    assign result.pm25_tenths  = pm25_reg;
    assign result.pm10_tenths  = pm10_reg;
    assign result.passive_mode = passive_reg;
    assign result.awake        = awake_reg;
    assign result.interval_min = interval_reg;
    assign result.fw_year      = fw_year_reg;
    assign result.fw_month     = fw_month_reg;
    assign result.fw_day       = fw_day_reg;
    assign result.sensor_id    = id_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= pmsrfp_pkg::POS_TAIL)
        else $error("frame position out of range");

    a_tail_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_tail |=> pos_reg == pmsrfp_pkg::POS_HUNT && out_valid_reg)
        else $error("tail word did not return to hunting with a result");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> in_valid_reg && is_tail && out_valid_reg && !result.ready)
        else $error("input stalled without a waiting result");

    a_hold_readings: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && is_tail && frame_ok) |=> $stable(pm25_reg) && $stable(pm10_reg))
        else $error("readings changed without a valid frame");

endmodule
